>>> design/assert_macros.svh
// Assertion macros used by the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define IMAD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("imad assertion failed");
// Expression must never be true outside reset.
`define IMAD_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("imad forbidden condition");
`else
`define IMAD_ASSERT(label, clk, rst_n, prop)
`define IMAD_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> design/imad_pkg.sv
// Types, constants and tables shared by the IMA ADPCM subframe decoder.
`timescale 1ns / 1ps
package imad_pkg;

    // Highest legal step index
    localparam logic [6:0] IDX_MAX = 7'd88;

    // Register word index of channel_count
    localparam logic REG_CHANNEL_COUNT = 1'b0;

    // Role of a byte within its part
    typedef enum logic [2:0] {
        K_HDR0,
        K_HDR1,
        K_HDR2,
        K_LOAD,
        K_DATA
    } t_kind;

    // One classified byte handed from the position tracker to the core
    typedef struct packed {
        t_kind      kind;
        logic       ch;
        logic [7:0] data;
    } t_item;

    // IMA ADPCM step size table
    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        unique case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Step index adjustment for the magnitude bits of a nibble
    function automatic logic signed [4:0] idx_adj(input logic [2:0] mag);
        logic signed [4:0] a;
        unique case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

>>> design/imad_seq.sv
// Subframe position tracker: classifies each accepted byte by part and offset.
`timescale 1ns / 1ps
module imad_seq
    import imad_pkg::*;
#(
    parameter int SUBFRAME_SAMPLES = 256,
    parameter int MAX_CHANNELS     = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_packet_start,
    input  logic [1:0] i_channels,
    output t_item      o_item
);

    localparam int PART_BYTES = 4 + SUBFRAME_SAMPLES / 2;
    localparam int FULL_BYTES = MAX_CHANNELS * PART_BYTES;
    localparam int POS_W      = $clog2(FULL_BYTES + 1);
    localparam int OFF_W      = $clog2(PART_BYTES + 1);

    localparam logic [POS_W-1:0] LIM_ONE  = POS_W'(PART_BYTES);
    localparam logic [POS_W-1:0] LIM_FULL = POS_W'(FULL_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] limit, pos0, pos_inc, pos_rel;
    logic             part_ch;
    logic [OFF_W-1:0] off;

    // Locate the byte: restart on packet start or when past the subframe
    always_comb begin
        limit = i_channels[1] ? LIM_FULL : LIM_ONE;
        pos0  = i_packet_start ? '0 : r_pos;
        if (pos0 >= limit) begin
            pos0 = '0;
        end
        part_ch = (MAX_CHANNELS > 1) && (pos0 >= LIM_ONE);
        pos_rel = part_ch ? (pos0 - LIM_ONE) : pos0;
        off     = pos_rel[OFF_W-1:0];
        pos_inc = pos0 + 1'b1;
        n_pos   = (pos_inc >= limit) ? '0 : pos_inc;
    end

    // Classify by offset within the part
    always_comb begin
        o_item.ch   = part_ch;
        o_item.data = i_data_byte;
        priority if (off == OFF_W'(0)) begin
            o_item.kind = K_HDR0;
        end else if (off == OFF_W'(1)) begin
            o_item.kind = K_HDR1;
        end else if (off == OFF_W'(2)) begin
            o_item.kind = K_HDR2;
        end else if (off == OFF_W'(3)) begin
            o_item.kind = K_LOAD;
        end else begin
            o_item.kind = K_DATA;
        end
    end

    // Advance position on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

>>> design/imad_core.sv
// Decode core: item register, channel state, nibble decoder and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module imad_core
    import imad_pkg::*;
#(
    parameter int MAX_CHANNELS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_item              i_item,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic               o_last
);

    t_item              r_item;
    logic               r_v;
    logic               r_phase;
    logic [23:0]        r_hh;
    logic signed [15:0] r_pred [MAX_CHANNELS];
    logic [6:0]         r_idx  [MAX_CHANNELS];
    logic               r_o_valid;
    logic signed [15:0] r_o_sample;
    logic               r_o_channel;
    logic               r_o_last;

    logic               is_data, out_free, step_fire, done, hi_sel;
    logic [3:0]         nib;
    logic signed [15:0] pred_sel;
    logic [6:0]         idx_sel;
    logic [14:0]        step;
    logic [18:0]        prod;
    logic signed [17:0] p_sum;
    logic signed [15:0] p_new;
    logic signed [7:0]  ni_sum;
    logic [6:0]         ni_new;
    logic signed [15:0] hdr_idx;
    logic [6:0]         load_idx;
    logic signed [15:0] load_pred;

    // Handshake on the item register
    assign is_data   = r_item.kind == K_DATA;
    assign out_free  = !r_o_valid || !i_stall;
    assign step_fire = r_v && is_data && out_free;
    assign done      = r_v && (!is_data || (r_phase && out_free));
    assign o_busy    = r_v && !done;
    assign hi_sel    = (MAX_CHANNELS > 1) && r_item.ch;

    // Select the channel state
    assign pred_sel = hi_sel ? r_pred[MAX_CHANNELS-1] : r_pred[0];
    assign idx_sel  = hi_sel ? r_idx[MAX_CHANNELS-1]  : r_idx[0];

    // Decode one nibble: low first, then high
    always_comb begin
        nib    = r_phase ? r_item.data[7:4] : r_item.data[3:0];
        step   = step_size(idx_sel);
        prod   = 19'(step) * 19'({nib[2:0], 1'b1});
        p_sum  = nib[3] ? (18'(pred_sel) - $signed({2'b00, prod[18:3]}))
                        : (18'(pred_sel) + $signed({2'b00, prod[18:3]}));
        if (p_sum > 18'sd32767) begin
            p_new = 16'sh7FFF;
        end else if (p_sum < -18'sd32768) begin
            p_new = -16'sh8000;
        end else begin
            p_new = p_sum[15:0];
        end
        ni_sum = $signed({1'b0, idx_sel}) + 8'(idx_adj(nib[2:0]));
        if (ni_sum < 8'sd0) begin
            ni_new = '0;
        end else if (ni_sum > $signed({1'b0, IDX_MAX})) begin
            ni_new = IDX_MAX;
        end else begin
            ni_new = ni_sum[6:0];
        end
    end

    // Header word: clamp the step index, assemble the predictor
    always_comb begin
        hdr_idx   = r_hh[15:0];
        load_pred = {r_item.data, r_hh[23:16]};
        if (hdr_idx[15]) begin
            load_idx = '0;
        end else if (hdr_idx > $signed({9'd0, IDX_MAX})) begin
            load_idx = IDX_MAX;
        end else begin
            load_idx = hdr_idx[6:0];
        end
    end

    // Item register and nibble phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_accept) begin
            r_v     <= 1'b1;
            r_phase <= 1'b0;
        end else if (done) begin
            r_v     <= 1'b0;
            r_phase <= 1'b0;
        end else if (step_fire) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    // Hold the first three header bytes
    always_ff @(posedge i_clk) begin
        if (r_v && r_item.kind == K_HDR0) begin
            r_hh[7:0] <= r_item.data;
        end
        if (r_v && r_item.kind == K_HDR1) begin
            r_hh[15:8] <= r_item.data;
        end
        if (r_v && r_item.kind == K_HDR2) begin
            r_hh[23:16] <= r_item.data;
        end
    end

    // Per-channel predictor and step index
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < MAX_CHANNELS; g++) begin
            if (!i_rst_n) begin
                r_pred[g] <= '0;
                r_idx[g]  <= '0;
            end else if ((MAX_CHANNELS == 1) || (r_item.ch == 1'(g))) begin
                if (step_fire) begin
                    r_pred[g] <= p_new;
                    r_idx[g]  <= ni_new;
                end else if (r_v && r_item.kind == K_LOAD) begin
                    r_pred[g] <= load_pred;
                    r_idx[g]  <= load_idx;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (step_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_o_sample  <= p_new;
            r_o_channel <= hi_sel;
            r_o_last    <= r_phase;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_sample  = r_o_sample;
    assign o_channel = r_o_channel;
    assign o_last    = r_o_last;

    // Checks
    `IMAD_ASSERT(a_phase_on_data, i_clk, i_rst_n, r_phase |-> (r_v && is_data))
    `IMAD_ASSERT(a_low_then_high, i_clk, i_rst_n, (step_fire && !r_phase) |=> (r_v && r_phase))
    `IMAD_ASSERT(a_data_ends_high, i_clk, i_rst_n, (done && is_data) |-> r_phase)
    `IMAD_NEVER(a_idx_range0, i_clk, i_rst_n, r_idx[0] > IDX_MAX)
    `IMAD_NEVER(a_idx_rangeN, i_clk, i_rst_n, r_idx[MAX_CHANNELS-1] > IDX_MAX)

endmodule

>>> design/ima_adpcm_subframe_decoder.sv
// Top level of the IMA ADPCM subframe decoder with its register port.
// Header byte: no result. Data byte: one sample per nibble, low first, from the single
// nibble decoder feeding one result register. A new byte waits for the high nibble.
// The low-nibble sample passes the item register, then the result register.
// Sustained rate: one sample per cycle while i_stall is low.
// Synchronous reset clears position, predictors, step indices; channel_count goes to 1.
`timescale 1ns / 1ps
module ima_adpcm_subframe_decoder
    import imad_pkg::*;
#(
    parameter int SUBFRAME_SAMPLES = 256,
    parameter int MAX_CHANNELS     = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_packet_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] MAX_CH = 2'(MAX_CHANNELS);

    logic [1:0] r_channel_count;
    logic [1:0] ch_eff;
    logic       accept, core_busy;
    t_item      item;

    // Register port: always ready, one register at word 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHANNEL_COUNT) ? {30'd0, r_channel_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 2'd1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_CHANNEL_COUNT) begin
            r_channel_count <= pwdata[1:0];
        end
    end

    // Clamp channel count into 1..MAX_CHANNELS
    always_comb begin
        priority if (r_channel_count == 2'd0) begin
            ch_eff = 2'd1;
        end else if (r_channel_count > MAX_CH) begin
            ch_eff = MAX_CH;
        end else begin
            ch_eff = r_channel_count;
        end
    end

    assign o_stall = core_busy;
    assign accept  = i_valid && !core_busy;

    imad_seq #(
        .SUBFRAME_SAMPLES (SUBFRAME_SAMPLES),
        .MAX_CHANNELS     (MAX_CHANNELS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_packet_start (i_packet_start),
        .i_channels     (ch_eff),
        .o_item         (item)
    );

    imad_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (item),
        .o_busy    (core_busy),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_sample  (o_sample),
        .o_channel (o_channel),
        .o_last    (o_last)
    );

endmodule
